@@ design/pfc_pkg.sv @@
package pfc_pkg;

  localparam int Side  = 5;
  localparam int Cells = 25;
  localparam int Alpha = 26;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_Z = 5'd25;

  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_KEY     = 3'd1;
  localparam logic [2:0] ACT_FINISH  = 3'd2;
  localparam logic [2:0] ACT_ENCRYPT = 3'd3;
  localparam logic [2:0] ACT_DECRYPT = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] letter_a;
    logic [4:0] letter_b;
  } in_word_t;

  typedef struct packed {
    logic [4:0] out_a;
    logic [4:0] out_b;
    logic       status;
  } out_word_t;

  // square position kept as {row, col}
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } sq_pos_t;

  // saturate above z, fold j onto i
  function automatic logic [4:0] norm_letter(input logic [4:0] v);
    logic [4:0] c;
    c = (v > LETTER_Z) ? LETTER_Z : v;
    if (c == LETTER_J) c = LETTER_I;
    return c;
  endfunction

  // linear cell index to row and column
  function automatic sq_pos_t pos_of(input logic [4:0] idx);
    sq_pos_t p;
    logic [4:0] base;
    if (idx >= 5'd20) begin
      p.row = 3'd4;
    end else if (idx >= 5'd15) begin
      p.row = 3'd3;
    end else if (idx >= 5'd10) begin
      p.row = 3'd2;
    end else if (idx >= 5'd5) begin
      p.row = 3'd1;
    end else begin
      p.row = 3'd0;
    end
    base  = 5'(5'(p.row) * 5'(Side));
    p.col = 3'(idx - base);
    return p;
  endfunction

  function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
    return 5'(5'(r) * 5'(Side) + 5'(c));
  endfunction

  // wrap by one step forward or back
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic back);
    logic [2:0] res;
    if (back) begin
      res = (v == 3'd0) ? 3'(Side - 1) : 3'(v - 3'd1);
    end else begin
      res = (v == 3'(Side - 1)) ? 3'd0 : 3'(v + 3'd1);
    end
    return res;
  endfunction

endpackage

@@ design/pfc_ram.sv @@
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/playfair_digraph_cipher_top.sv @@
// Playfair cipher on a 5x5 key square. A command word is taken when start is high and
// busy is low; every command gives exactly one result word, shown on out_data for one
// cycle with out_valid high, and the receiver cannot stall it. Clear, key letter, an
// unused action code, a finish on a ready square and a pair refused because the square
// is not finished give their result in the cycle after acceptance, and the next command
// may be taken in that same cycle. An encrypt or decrypt pair keeps busy high in S_POS_B,
// S_CELL_A, S_CELL_B and S_DONE, and its result is registered from S_DONE: the position
// memory and the square memory have one read port each, so the two position reads and
// the two letter reads run one a cycle. A finish on an unfinished square walks the
// alphabet one letter a cycle. Letters above z read as z and j reads as i on every input.
module playfair_digraph_cipher_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pfc_pkg::in_word_t  in_data,
  output logic              out_valid,
  output pfc_pkg::out_word_t out_data
);

  import pfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_POS_B,
    S_CELL_A,
    S_CELL_B,
    S_DONE
  } state_t;

  state_t    state_r, state_nxt;
  logic [25:0] used_r, used_nxt;       // letter already placed
  logic [4:0]  fill_r, fill_nxt;       // cells filled so far
  logic        ready_r, ready_nxt;     // square complete
  logic [4:0]  fctr_r, fctr_nxt;       // alphabet walk for finish
  logic [4:0]  a_r, a_nxt;
  logic [4:0]  b_r, b_nxt;
  logic        dec_r, dec_nxt;
  sq_pos_t     posa_r, posa_nxt;
  logic [4:0]  n2_r, n2_nxt;
  logic [4:0]  ra_r, ra_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  // memory ports
  logic       sq_we, pos_we;
  logic [4:0] sq_raddr, pos_raddr;
  logic [4:0] sq_rdata;
  sq_pos_t    pos_rdata;
  sq_pos_t    pos_wdata;

  // shared letter placement
  logic       place_en;
  logic [4:0] place_c;

  logic       accept;
  logic [4:0] na, nb;
  sq_pos_t    pb;
  logic [2:0] r1, c1, r2, c2;
  logic [4:0] n1, n2;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign na        = norm_letter(in_data.letter_a);
  assign nb        = norm_letter(in_data.letter_b);
  assign pos_wdata = pos_of(fill_r);

  // pair rule from the two positions
  always_comb begin
    pb = pos_rdata;
    r1 = posa_r.row;
    c1 = posa_r.col;
    r2 = pb.row;
    c2 = pb.col;
    if (c1 == c2) begin
      // same column (also a repeated letter): move down, up on decryption
      n1 = cell_idx(wrap_step(r1, dec_r), c1);
      n2 = cell_idx(wrap_step(r2, dec_r), c2);
    end else if (r1 == r2) begin
      // same row: move right, left on decryption
      n1 = cell_idx(r1, wrap_step(c1, dec_r));
      n2 = cell_idx(r2, wrap_step(c2, dec_r));
    end else begin
      // rectangle: swap columns
      n1 = cell_idx(r1, c2);
      n2 = cell_idx(r2, c1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    ready_nxt     = ready_r;
    fctr_nxt      = fctr_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    dec_nxt       = dec_r;
    posa_nxt      = posa_r;
    n2_nxt        = n2_r;
    ra_nxt        = ra_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    sq_we         = 1'b0;
    pos_we        = 1'b0;
    sq_raddr      = n1;
    pos_raddr     = b_r;
    place_en      = 1'b0;
    place_c       = fctr_r;

    unique case (state_r)
      S_IDLE: begin
        pos_raddr = na;
        if (accept) begin
          a_nxt   = na;
          b_nxt   = nb;
          dec_nxt = (in_data.action == ACT_DECRYPT);
          out_word_nxt = '0;
          unique case (in_data.action) inside
            ACT_CLEAR: begin
              used_nxt      = '0;
              fill_nxt      = '0;
              ready_nxt     = 1'b0;
              out_valid_nxt = 1'b1;
            end
            ACT_KEY: begin
              // ignored once the square is ready
              place_en      = !ready_r;
              place_c       = na;
              out_valid_nxt = 1'b1;
            end
            ACT_FINISH: begin
              if (ready_r) begin
                out_valid_nxt = 1'b1;
              end else begin
                fctr_nxt  = '0;
                state_nxt = S_FILL;
              end
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
              if (!ready_r) begin
                // pair refused
                out_word_nxt.status = 1'b1;
                out_valid_nxt       = 1'b1;
              end else begin
                // position of first letter is being read
                state_nxt = S_POS_B;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        if (fctr_r == 5'(Alpha - 1)) begin
          // last step places z, then the square is ready
          place_en      = 1'b1;
          ready_nxt     = 1'b1;
          out_word_nxt  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          place_en = (fctr_r != LETTER_J);
          fctr_nxt = 5'(fctr_r + 5'd1);
        end
      end
      S_POS_B: begin
        posa_nxt  = pos_rdata;
        pos_raddr = b_r;
        state_nxt = S_CELL_A;
      end
      S_CELL_A: begin
        sq_raddr  = n1;
        n2_nxt    = n2;
        state_nxt = S_CELL_B;
      end
      S_CELL_B: begin
        ra_nxt    = sq_rdata;
        sq_raddr  = n2_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_word_nxt.out_a  = ra_r;
        out_word_nxt.out_b  = sq_rdata;
        out_word_nxt.status = 1'b0;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // place a letter at the next free cell if new and room is left
    if (place_en && (fill_r < 5'(Cells)) && !used_r[place_c]) begin
      used_nxt[place_c] = 1'b1;
      sq_we             = 1'b1;
      pos_we            = 1'b1;
      fill_nxt          = 5'(fill_r + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      ready_r     <= 1'b0;
      fctr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      ready_r     <= ready_nxt;
      fctr_r      <= fctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    dec_r      <= dec_nxt;
    posa_r     <= posa_nxt;
    n2_r       <= n2_nxt;
    ra_r       <= ra_nxt;
    out_word_r <= out_word_nxt;
  end

  // letter at each cell
  pfc_ram #(
    .WIDTH (5),
    .DEPTH (Cells)
  ) u_square (
    .clk   (clk),
    .we    (sq_we),
    .waddr (fill_r),
    .wdata (place_c),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // {row, col} of each placed letter
  pfc_ram #(
    .WIDTH (6),
    .DEPTH (Alpha)
  ) u_position (
    .clk   (clk),
    .we    (pos_we),
    .waddr (place_c),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

endmodule
